/* src/usb_printer_endpoint_finder_defines.svh */
// ----------------------------------------------------------------------------
// usb_printer_endpoint_finder_defines
// Assertion macros used by the endpoint finder walker module.
// ----------------------------------------------------------------------------
`ifndef USB_PRINTER_ENDPOINT_FINDER_DEFINES_SVH
`define USB_PRINTER_ENDPOINT_FINDER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define UPEF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UPEF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/upef_pkg.sv */
// ----------------------------------------------------------------------------
// upef_pkg
// Types and constants of the USB printer endpoint finder.
// ----------------------------------------------------------------------------
package upef_pkg;

    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'd5;
    localparam logic [7:0] MIN_DESC_LENGTH     = 8'd2;
    localparam logic [1:0] XFER_TYPE_BULK      = 2'd2;
    localparam logic [7:0] TARGET_CLASS_RESET  = 8'd7;
    localparam logic       REG_TARGET_CLASS    = 1'b0;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } upef_step_t;

    typedef struct packed {
        logic [15:0] out_max_packet;
        logic [15:0] in_max_packet;
        logic [7:0]  out_endpoint_address;
        logic [7:0]  in_endpoint_address;
        logic [7:0]  interface_number;
        logic        found;
    } upef_result_t;

endpackage

/* src/upef_walker.sv */
// ----------------------------------------------------------------------------
// upef_walker
// Descriptor walk state and per-byte decision logic; one byte per cycle while step_valid is high.
// ----------------------------------------------------------------------------
`include "usb_printer_endpoint_finder_defines.svh"

module upef_walker
    import upef_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_valid,
    input  upef_step_t   step,
    input  logic [7:0]   target_class,
    output logic         res_valid,
    output upef_result_t res
);

    logic [7:0]  byte_offset_reg, byte_offset_next;
    logic [7:0]  desc_length_reg, desc_length_next;
    logic [7:0]  desc_type_reg, desc_type_next;
    logic [7:0]  capt_reg [4];
    logic [7:0]  capt_next [4];
    logic        in_target_reg, in_target_next;
    logic        have_in_reg, have_in_next;
    logic        have_out_reg, have_out_next;
    logic        walk_finished_reg, walk_finished_next;
    logic [7:0]  cur_if_reg, cur_if_next;
    logic [7:0]  in_addr_reg, in_addr_next;
    logic [15:0] in_mps_reg, in_mps_next;
    logic [7:0]  out_addr_reg, out_addr_next;
    logic [15:0] out_mps_reg, out_mps_next;

    logic [7:0]  off_m2;

    assign off_m2 = byte_offset_reg - MIN_DESC_LENGTH;

    always_comb begin
        byte_offset_next   = byte_offset_reg;
        desc_length_next   = desc_length_reg;
        desc_type_next     = desc_type_reg;
        for (int i = 0; i < 4; i++) begin
            capt_next[i] = capt_reg[i];
        end
        in_target_next     = in_target_reg;
        have_in_next       = have_in_reg;
        have_out_next      = have_out_reg;
        walk_finished_next = walk_finished_reg;
        cur_if_next        = cur_if_reg;
        in_addr_next       = in_addr_reg;
        in_mps_next        = in_mps_reg;
        out_addr_next      = out_addr_reg;
        out_mps_next       = out_mps_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (!walk_finished_reg) begin
            if (byte_offset_reg == 8'd0) begin
                desc_length_next = step.data;
                for (int i = 0; i < 4; i++) begin
                    capt_next[i] = 8'd0;
                end
                if (step.data < MIN_DESC_LENGTH) begin
                    walk_finished_next = 1'b1;
                end else begin
                    byte_offset_next = 8'd1;
                end
            end else begin
                if (byte_offset_reg == 8'd1) begin
                    desc_type_next = step.data;
                end else if (byte_offset_reg <= 8'd5) begin
                    capt_next[off_m2[1:0]] = step.data;
                end
                if ({1'b0, byte_offset_reg} + 9'd1 == {1'b0, desc_length_reg}) begin
                    byte_offset_next = 8'd0;
                    if (desc_type_next == DESC_TYPE_INTERFACE) begin
                        if (capt_next[3] == target_class) begin
                            in_target_next = 1'b1;
                            cur_if_next    = capt_next[0];
                            have_in_next   = 1'b0;
                            have_out_next  = 1'b0;
                        end else begin
                            in_target_next = 1'b0;
                        end
                    end else if (in_target_reg && desc_type_next == DESC_TYPE_ENDPOINT &&
                                 capt_next[1][1:0] == XFER_TYPE_BULK) begin
                        if (capt_next[0][7]) begin
                            in_addr_next = capt_next[0];
                            in_mps_next  = {capt_next[3], capt_next[2]};
                            have_in_next = 1'b1;
                        end else begin
                            out_addr_next = capt_next[0];
                            out_mps_next  = {capt_next[3], capt_next[2]};
                            have_out_next = 1'b1;
                        end
                        if (have_in_next && have_out_next) begin
                            walk_finished_next       = 1'b1;
                            res_valid                = 1'b1;
                            res.found                = 1'b1;
                            res.interface_number     = cur_if_next;
                            res.in_endpoint_address  = in_addr_next;
                            res.out_endpoint_address = out_addr_next;
                            res.in_max_packet        = in_mps_next;
                            res.out_max_packet       = out_mps_next;
                        end
                    end
                end else begin
                    byte_offset_next = byte_offset_reg + 8'd1;
                end
            end
        end

        if (step.last) begin
            if (!res_valid && !(have_in_next && have_out_next)) begin
                res_valid = 1'b1;
                res       = '0;
            end
            byte_offset_next   = 8'd0;
            desc_length_next   = 8'd0;
            desc_type_next     = 8'd0;
            for (int i = 0; i < 4; i++) begin
                capt_next[i] = 8'd0;
            end
            in_target_next     = 1'b0;
            have_in_next       = 1'b0;
            have_out_next      = 1'b0;
            walk_finished_next = 1'b0;
            cur_if_next        = 8'd0;
            in_addr_next       = 8'd0;
            in_mps_next        = 16'd0;
            out_addr_next      = 8'd0;
            out_mps_next       = 16'd0;
        end

        if (!step_valid) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg   <= 8'd0;
            desc_length_reg   <= 8'd0;
            desc_type_reg     <= 8'd0;
            for (int i = 0; i < 4; i++) begin
                capt_reg[i] <= 8'd0;
            end
            in_target_reg     <= 1'b0;
            have_in_reg       <= 1'b0;
            have_out_reg      <= 1'b0;
            walk_finished_reg <= 1'b0;
            cur_if_reg        <= 8'd0;
            in_addr_reg       <= 8'd0;
            in_mps_reg        <= 16'd0;
            out_addr_reg      <= 8'd0;
            out_mps_reg       <= 16'd0;
        end else if (step_valid) begin
            byte_offset_reg   <= byte_offset_next;
            desc_length_reg   <= desc_length_next;
            desc_type_reg     <= desc_type_next;
            for (int i = 0; i < 4; i++) begin
                capt_reg[i] <= capt_next[i];
            end
            in_target_reg     <= in_target_next;
            have_in_reg       <= have_in_next;
            have_out_reg      <= have_out_next;
            walk_finished_reg <= walk_finished_next;
            cur_if_reg        <= cur_if_next;
            in_addr_reg       <= in_addr_next;
            in_mps_reg        <= in_mps_next;
            out_addr_reg      <= out_addr_next;
            out_mps_reg       <= out_mps_next;
        end
    end

    `UPEF_ASSERT(a_offset_in_desc, byte_offset_reg != 8'd0, byte_offset_reg < desc_length_reg, "byte offset past descriptor length")
    `UPEF_ASSERT(a_quiet_after_stop, step_valid && walk_finished_reg && !step.last, !res_valid, "result while walk is stopped")
    `UPEF_ASSERT_NEXT(a_stop_on_match, step_valid && res_valid && res.found && !step.last, walk_finished_reg && have_in_reg && have_out_reg, "walk not stopped after match")

endmodule

/* src/upef_out_buf.sv */
// ----------------------------------------------------------------------------
// upef_out_buf
// Result register on the master side of the stream.
// ----------------------------------------------------------------------------
module upef_out_buf
    import upef_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  upef_result_t load_data,
    output logic         can_load,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata   // found, interface_number, in_endpoint_address,
                                   // out_endpoint_address, in_max_packet,
                                   // out_max_packet, zero pad
);

    logic         out_valid_reg;
    upef_result_t out_data_reg;

    assign can_load = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= load_data;
        end
    end

endmodule

/* src/usb_printer_endpoint_finder.sv */
// ----------------------------------------------------------------------------
// usb_printer_endpoint_finder
// Walks a USB configuration descriptor set and reports a bulk IN/OUT pair.
// ----------------------------------------------------------------------------
// Takes one descriptor byte per cycle unless the result stream back-pressures,
// with no gaps required between bytes. Each byte passes an input register,
// the combinational walker logic and the result register. A set yields
// exactly one result: found as soon as the matching interface has shown both
// bulk endpoints, else not-found on the tlast byte. target_class sits at APB
// address 0 and must be written only while idle; the block does not enforce this.
module usb_printer_endpoint_finder
    import upef_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // descriptor_byte
    input  logic        s_tlast,

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // found, interface_number, in_endpoint_address,
                                   // out_endpoint_address, in_max_packet,
                                   // out_max_packet, zero pad

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic         in_valid_reg;
    upef_step_t   in_step_reg;
    logic [7:0]   target_class_reg;
    logic         can_load;
    logic         fire;
    logic         res_valid;
    upef_result_t res;

    assign pready = 1'b1;

    always_comb begin
        if (paddr[2] == REG_TARGET_CLASS) begin
            prdata = {24'd0, target_class_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_class_reg <= TARGET_CLASS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TARGET_CLASS) begin
            target_class_reg <= pwdata[7:0];
        end
    end

    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_step_reg.data <= s_tdata;
            in_step_reg.last <= s_tlast;
        end
    end

    upef_walker u_walker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_valid   (fire),
        .step         (in_step_reg),
        .target_class (target_class_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    upef_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_data (res),
        .can_load  (can_load),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
